>>> rtl/lpht_pkg.sv
`default_nettype none

package lpht_pkg;

  // Table geometry
  localparam int SLOTS      = 64;
  localparam int IDX_W      = $clog2(SLOTS);
  localparam int CNT_W      = $clog2(SLOTS + 1);
  localparam int KEY_BITS   = 64;
  localparam int HASH_BITS  = 32;
  localparam int VALUE_BITS = 32;
  localparam int LIMIT_W    = 7;

  localparam logic [LIMIT_W-1:0] LOAD_LIMIT_RESET = LIMIT_W'(48);

  typedef enum logic [1:0] {
    CMD_SET = 2'd0,
    CMD_GET = 2'd1,
    CMD_DEL = 2'd2,
    CMD_NOP = 2'd3
  } cmd_t;

  // Request transaction
  typedef struct packed {
    cmd_t                  cmd;
    logic [KEY_BITS-1:0]   key;
    logic [HASH_BITS-1:0]  key_hash;
    logic [VALUE_BITS-1:0] value;
  } req_t;

  // Response transaction
  typedef struct packed {
    logic                  hit;
    logic                  rejected;
    logic [VALUE_BITS-1:0] read_value;
  } rsp_t;

  // One slot as held in the slot RAM; empty slots are tracked by valid flops
  typedef struct packed {
    logic                  tomb;
    logic [KEY_BITS-1:0]   key;
    logic [HASH_BITS-1:0]  hash;
    logic [VALUE_BITS-1:0] value;
  } slot_entry_t;

  typedef struct packed {
    logic              en;
    logic [IDX_W-1:0]  addr;
    slot_entry_t       data;
  } slot_wr_t;

  typedef struct packed {
    logic push;
    rsp_t item;
  } res_push_t;

endpackage

`default_nettype wire

>>> rtl/linear_probe_hash_table_core.sv
// Channel | Direction | Handshake            | Payload
// req     | in        | req_valid/req_stall  | lpht_pkg::req_t (cmd, key, key_hash, value)
// rsp     | out       | rsp_valid/rsp_stall  | lpht_pkg::rsp_t (hit, rejected, read_value)
// cfg     | in        | cfg_valid/cfg_ready  | load_limit, 7 bits
//
// An item probes k slots (1 to 64) and then finishes; the slot RAM delivers
// one slot per cycle. Command 3 skips the probe and goes straight to finish.
// Reset is synchronous: all slots empty, count zero, load_limit 48; no
// clearing pass. A stalled response waits in the output register; the next
// request is still taken and holds until that slot frees.
`default_nettype none

module linear_probe_hash_table_core (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         req_valid,
  output      logic                         req_stall,
  input  wire lpht_pkg::req_t               req,
  output      logic                         rsp_valid,
  input  wire logic                         rsp_stall,
  output      lpht_pkg::rsp_t               rsp,
  input  wire logic                         cfg_valid,
  output      logic                         cfg_ready,
  input  wire logic [lpht_pkg::LIMIT_W-1:0] cfg_data
);
  import lpht_pkg::*;

  logic [LIMIT_W-1:0] load_limit;
  logic [IDX_W-1:0]   rd_addr;
  slot_entry_t        rd_data;
  slot_wr_t           wr;
  res_push_t          res;
  logic               res_room;
  logic               busy;

  assign req_stall = busy;
  assign cfg_ready = 1'b1;
  assign res_room  = !rsp_valid || !rsp_stall;

  // Load limit register
  always_ff @(posedge clk) begin
    if (rst) begin
      load_limit <= LOAD_LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      load_limit <= cfg_data;
    end
  end

  // Response output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (res.push) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
    if (res.push) begin
      rsp <= res.item;
    end
  end

  lpht_probe_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req        (req),
    .busy       (busy),
    .load_limit (load_limit),
    .res_room   (res_room),
    .res        (res),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data),
    .wr         (wr)
  );

  lpht_slot_ram u_ram (
    .clk     (clk),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr      (wr)
  );

endmodule

`default_nettype wire

>>> rtl/lpht_slot_ram.sv
`default_nettype none

module lpht_slot_ram (
  input  wire logic                      clk,
  input  wire logic [lpht_pkg::IDX_W-1:0] rd_addr,
  output      lpht_pkg::slot_entry_t     rd_data,
  input  wire lpht_pkg::slot_wr_t        wr
);
  import lpht_pkg::*;

  slot_entry_t mem [SLOTS];

  // Single write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

>>> rtl/lpht_probe_ctrl.sv
`default_nettype none

module lpht_probe_ctrl (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          req_valid,
  input  wire lpht_pkg::req_t                req,
  output      logic                          busy,
  input  wire logic [lpht_pkg::LIMIT_W-1:0]  load_limit,
  input  wire logic                          res_room,
  output      lpht_pkg::res_push_t           res,
  output      logic [lpht_pkg::IDX_W-1:0]    rd_addr,
  input  wire lpht_pkg::slot_entry_t         rd_data,
  output      lpht_pkg::slot_wr_t            wr
);
  import lpht_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_PROBE,
    S_FINISH
  } state_t;

  state_t                state;
  req_t                  item;
  logic [SLOTS-1:0]      slot_valid;
  logic [CNT_W-1:0]      used_slots;
  logic [IDX_W-1:0]      cur_addr;
  logic                  cur_valid;
  logic [IDX_W-1:0]      steps;
  logic [IDX_W-1:0]      at_addr;
  logic [IDX_W-1:0]      tomb_addr;
  logic                  found;
  logic                  have_tomb;
  logic                  have_empty;
  logic [VALUE_BITS-1:0] found_value;

  logic is_empty;
  logic is_match;
  logic is_tomb;
  logic over_limit;
  logic take_empty;
  logic finish_go;

  // Read address: start slot while idle, else the slot after the one in view
  always_comb begin
    if (state == S_IDLE) begin
      rd_addr = req.key_hash[IDX_W-1:0];
    end else begin
      rd_addr = cur_addr + IDX_W'(1);
    end
  end

  assign busy = (state != S_IDLE);

  // Classify the slot in view
  assign is_empty = !cur_valid;
  assign is_match = cur_valid && !rd_data.tomb
                    && (rd_data.hash == item.key_hash) && (rd_data.key == item.key);
  assign is_tomb  = cur_valid && rd_data.tomb;

  assign over_limit = ((CNT_W + 1)'(used_slots) + (CNT_W + 1)'(1))
                      > (CNT_W + 1)'(load_limit);
  assign finish_go  = (state == S_FINISH) && res_room;

  // Outcome of a finished probe: slot write and response
  always_comb begin
    wr.en             = 1'b0;
    wr.addr           = at_addr;
    wr.data.tomb      = 1'b0;
    wr.data.key       = item.key;
    wr.data.hash      = item.key_hash;
    wr.data.value     = item.value;
    res.push          = finish_go;
    res.item.hit      = 1'b0;
    res.item.rejected = 1'b0;
    res.item.read_value = '0;
    take_empty        = 1'b0;
    case (item.cmd)
      CMD_GET: begin
        res.item.hit = found;
        if (found) begin
          res.item.read_value = found_value;
        end
      end
      CMD_DEL: begin
        if (found) begin
          wr.en         = 1'b1;
          wr.data.tomb  = 1'b1;
          res.item.hit  = 1'b1;
        end
      end
      CMD_SET: begin
        if (found) begin
          wr.en = 1'b1;
        end else if (have_tomb) begin
          wr.en        = 1'b1;
          wr.addr      = tomb_addr;
          res.item.hit = 1'b1;
        end else if (have_empty && !over_limit) begin
          wr.en        = 1'b1;
          take_empty   = 1'b1;
          res.item.hit = 1'b1;
        end else begin
          res.item.rejected = 1'b1;
        end
      end
      default: begin
      end
    endcase
    wr.en      = wr.en && finish_go;
    take_empty = take_empty && finish_go;
  end

  // Sequencer: accept, walk one slot per cycle, then write back and respond
  always_ff @(posedge clk) begin
    cur_addr  <= rd_addr;
    cur_valid <= slot_valid[rd_addr];
    if (rst) begin
      state      <= S_IDLE;
      slot_valid <= '0;
      used_slots <= '0;
      found      <= 1'b0;
      have_tomb  <= 1'b0;
      have_empty <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            item       <= req;
            steps      <= '0;
            found      <= 1'b0;
            have_tomb  <= 1'b0;
            have_empty <= 1'b0;
            state      <= (req.cmd == CMD_NOP) ? S_FINISH : S_PROBE;
          end
        end
        S_PROBE: begin
          steps <= steps + IDX_W'(1);
          if (is_empty) begin
            have_empty <= 1'b1;
            at_addr    <= cur_addr;
            state      <= S_FINISH;
          end else if (is_match) begin
            found       <= 1'b1;
            at_addr     <= cur_addr;
            found_value <= rd_data.value;
            state       <= S_FINISH;
          end else begin
            if (is_tomb && !have_tomb) begin
              have_tomb <= 1'b1;
              tomb_addr <= cur_addr;
            end
            // whole ring seen without an empty slot
            if (steps == IDX_W'(SLOTS - 1)) begin
              state <= S_FINISH;
            end
          end
        end
        S_FINISH: begin
          if (res_room) begin
            if (take_empty) begin
              slot_valid[at_addr] <= 1'b1;
              used_slots          <= used_slots + CNT_W'(1);
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Checks
  a_used_bounded: assert property (@(posedge clk) disable iff (rst)
    used_slots <= CNT_W'(SLOTS))
    else $error("used slot count above capacity");

  a_used_step: assert property (@(posedge clk) disable iff (rst)
    take_empty |=> used_slots == $past(used_slots) + CNT_W'(1))
    else $error("used slot count not bumped on fresh slot");

  a_probe_walk: assert property (@(posedge clk) disable iff (rst)
    (state == S_PROBE && $past(state == S_PROBE)) |-> cur_addr == $past(cur_addr) + IDX_W'(1))
    else $error("probe skipped a slot");

  a_write_only_on_finish: assert property (@(posedge clk) disable iff (rst)
    wr.en |-> res.push)
    else $error("slot write without a response");

  a_hit_reject_excl: assert property (@(posedge clk) disable iff (rst)
    res.push |-> !(res.item.hit && res.item.rejected))
    else $error("response both hit and rejected");

endmodule

`default_nettype wire
